// ===== rtl/mtwg_pkg.sv =====
// Shared constants and command types for the Mersenne twister word generator.
package mtwg_pkg;

	localparam int unsigned STATE_DEPTH = 624;
	localparam int unsigned TAP_OFFSET  = 397;
	localparam int unsigned ADDR_W      = 10;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned TRY_LIMIT   = 2 * STATE_DEPTH;
	localparam int unsigned TRY_W       = $clog2(TRY_LIMIT);

	localparam logic [WORD_W-1:0] FEEDBACK = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              addr_ok;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] word;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

endpackage

// ===== rtl/mersenne_twister_word_generator.sv =====
// Top level of the Mersenne twister word generator: command queue, generator core, result queue.
// A draw's word passes the read register, the tempering register and the result queue. Draws run
// at one item per cycle while the result queue has room, but a tempered zero word is skipped by
// a fresh read of the state memory. A load waits for draws in flight to finish and, if it is
// in a twisted block, for its remaining words to be twisted at one word per cycle (at most 623).
// Reset clears the queues, the read position and the pipeline; state words must be loaded first.
module mersenne_twister_word_generator #(
	parameter int unsigned CMD_DEPTH = 4,
	parameter int unsigned RES_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          command,
	input  logic [mtwg_pkg::ADDR_W-1:0]   load_addr,
	input  logic [mtwg_pkg::WORD_W-1:0]   load_word,
	output logic                          word_valid,
	input  logic                          word_stall,
	output logic [mtwg_pkg::WORD_W-1:0]   random_word
);

	localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

	mtwg_pkg::cmd_head_t           head;
	logic                          pop;
	logic [CNT_W-1:0]              res_count;
	logic                          push;
	logic [mtwg_pkg::WORD_W-1:0]   push_word;

	mtwg_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command  (command),
		.load_addr(load_addr),
		.load_word(load_word),
		.head     (head),
		.pop      (pop)
	);

	mtwg_back #(
		.RES_DEPTH(RES_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.res_count(res_count),
		.push     (push),
		.push_word(push_word)
	);

	mtwg_result_fifo #(
		.RES_DEPTH(RES_DEPTH)
	) u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.res_count  (res_count),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.random_word(random_word)
	);

endmodule

// ===== rtl/mtwg_front.sv =====
// Front part: accepts items, classifies them and holds them in a short command queue.
module mtwg_front #(
	parameter int unsigned CMD_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic                              command,
	input  logic [mtwg_pkg::ADDR_W-1:0]       load_addr,
	input  logic [mtwg_pkg::WORD_W-1:0]       load_word,
	output mtwg_pkg::cmd_head_t               head,
	input  logic                              pop
);

	localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

	mtwg_pkg::cmd_t   queue_q [CMD_DEPTH];
	mtwg_pkg::cmd_t   in_cmd;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             do_pop;

	always_comb begin
		in_cmd.op      = command ? mtwg_pkg::OP_DRAW : mtwg_pkg::OP_LOAD;
		in_cmd.addr_ok = (load_addr < mtwg_pkg::ADDR_W'(mtwg_pkg::STATE_DEPTH));
		in_cmd.addr    = load_addr;
		in_cmd.word    = load_word;
	end

	assign cmd_stall  = (count_q == CNT_W'(CMD_DEPTH));
	assign push       = cmd_valid && !cmd_stall;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10: begin
					count_q <= count_q + CNT_W'(1);
				end
				2'b01: begin
					count_q <= count_q - CNT_W'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/mtwg_back.sv =====
// Back part: state memory, incremental twist, tempering and zero-word skipping.
module mtwg_back #(
	parameter int unsigned RES_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mtwg_pkg::cmd_head_t                 head,
	output logic                                pop,
	input  logic [$clog2(RES_DEPTH + 1)-1:0]    res_count,
	output logic                                push,
	output logic [mtwg_pkg::WORD_W-1:0]         push_word
);

	localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
	localparam int unsigned AW    = mtwg_pkg::ADDR_W;
	localparam int unsigned WW    = mtwg_pkg::WORD_W;
	localparam logic [AW-1:0] DEPTH_A  = AW'(mtwg_pkg::STATE_DEPTH);
	localparam logic [AW-1:0] LAST_A   = AW'(mtwg_pkg::STATE_DEPTH - 1);
	localparam logic [AW-1:0] TAP_A    = AW'(mtwg_pkg::TAP_OFFSET);
	localparam logic [AW-1:0] TAP_WRAP = AW'(mtwg_pkg::STATE_DEPTH - mtwg_pkg::TAP_OFFSET);

	function automatic logic [WW-1:0] temper(input logic [WW-1:0] w);
		logic [WW-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & mtwg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtwg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [WW-1:0] mix(input logic hi, input logic [WW-1:0] lo,
		input logic [WW-1:0] tap);
		logic [WW-1:0] s;
		s = {hi, lo[WW-2:0]};
		return tap ^ (s >> 1) ^ (s[0] ? mtwg_pkg::FEEDBACK : '0);
	endfunction

	logic [WW-1:0] state_mem_q [mtwg_pkg::STATE_DEPTH];

	logic [AW-1:0]                 pos_q;
	logic                          twist_q;
	logic                          hi_q;
	logic                          w0hi_q;
	logic [mtwg_pkg::TRY_W-1:0]    zero_run_q;

	logic          valid_s1;
	logic          draw_s1;
	logic          twist_s1;
	logic [AW-1:0] pos_s1;
	logic [WW-1:0] rd_a_s1;
	logic [WW-1:0] rd_b_s1;

	logic          valid_s2;
	logic          draw_s2;
	logic [WW-1:0] tw_s2;

	logic          wrap;
	logic [AW-1:0] fetch_pos;
	logic          fetch_twist;
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;
	logic          issue;
	logic          issue_draw;
	logic          load_do;
	logic          draw_busy;
	logic          credit_ok;
	logic [CNT_W:0] need;
	logic          tw_zero;
	logic          at_limit;
	logic          refetch;
	logic          hi_sel;
	logic [WW-1:0] word_s1;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;

	assign tw_zero   = (tw_s2 == '0);
	assign at_limit  = (zero_run_q == mtwg_pkg::TRY_W'(mtwg_pkg::TRY_LIMIT - 1));
	assign push      = valid_s2 && draw_s2 && !tw_zero;
	assign push_word = tw_s2;
	assign refetch   = valid_s2 && draw_s2 && tw_zero && !at_limit;

	assign draw_busy = (valid_s1 && draw_s1) || (valid_s2 && draw_s2);
	assign need      = (CNT_W + 1)'(res_count) + (CNT_W + 1)'(valid_s1 && draw_s1)
		+ (CNT_W + 1)'(valid_s2 && draw_s2);
	assign credit_ok = (need < (CNT_W + 1)'(RES_DEPTH));

	assign wrap        = (pos_q == DEPTH_A);
	assign fetch_pos   = wrap ? '0 : pos_q;
	assign fetch_twist = wrap || twist_q;
	assign addr_a      = !fetch_twist ? fetch_pos :
		((fetch_pos == LAST_A) ? '0 : fetch_pos + AW'(1));
	assign addr_b      = (fetch_pos < TAP_WRAP) ? fetch_pos + TAP_A : fetch_pos - TAP_WRAP;

	always_comb begin
		issue      = 1'b0;
		issue_draw = 1'b0;
		pop        = 1'b0;
		load_do    = 1'b0;
		if (refetch) begin
			issue      = 1'b1;
			issue_draw = 1'b1;
		end else if (head.valid) begin
			case (head.cmd.op)
				mtwg_pkg::OP_DRAW: begin
					if (credit_ok) begin
						issue      = 1'b1;
						issue_draw = 1'b1;
						pop        = 1'b1;
					end
				end
				mtwg_pkg::OP_LOAD: begin
					if (!draw_busy) begin
						if (twist_q && !wrap) begin
							issue = 1'b1;
						end else if (!valid_s1 && !valid_s2) begin
							load_do = 1'b1;
							pop     = 1'b1;
						end
					end
				end
				default: begin
					issue = 1'b0;
				end
			endcase
		end
	end

	assign hi_sel  = (pos_s1 == '0) ? w0hi_q : hi_q;
	assign word_s1 = twist_s1 ? mix(hi_sel, rd_a_s1, rd_b_s1) : rd_a_s1;

	assign mem_we    = (valid_s1 && twist_s1) || (load_do && head.cmd.addr_ok);
	assign mem_waddr = load_do ? head.cmd.addr : pos_s1;
	assign mem_wdata = load_do ? head.cmd.word : word_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem_q[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_a_s1 <= state_mem_q[addr_a];
			rd_b_s1 <= state_mem_q[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			draw_s1  <= issue_draw;
			twist_s1 <= fetch_twist;
			pos_s1   <= fetch_pos;
		end
		if (valid_s1) begin
			draw_s2 <= draw_s1;
			tw_s2   <= temper(word_s1);
		end
		if (valid_s1 && twist_s1) begin
			hi_q <= rd_a_s1[WW-1];
		end
		if (mem_we && (mem_waddr == '0)) begin
			w0hi_q <= mem_wdata[WW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			twist_q    <= 1'b0;
			zero_run_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (issue) begin
				pos_q   <= fetch_pos + AW'(1);
				twist_q <= fetch_twist;
			end else if (load_do) begin
				pos_q   <= '0;
				twist_q <= 1'b0;
			end
			if (valid_s2 && draw_s2) begin
				if (!tw_zero || at_limit) begin
					zero_run_q <= '0;
				end else begin
					zero_run_q <= zero_run_q + mtwg_pkg::TRY_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/mtwg_result_fifo.sv =====
// Result queue that holds tempered words until the output side takes them.
module mtwg_result_fifo #(
	parameter int unsigned RES_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [mtwg_pkg::WORD_W-1:0]         push_word,
	output logic [$clog2(RES_DEPTH + 1)-1:0]    res_count,
	output logic                                word_valid,
	input  logic                                word_stall,
	output logic [mtwg_pkg::WORD_W-1:0]         random_word
);

	localparam int unsigned PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

	logic [mtwg_pkg::WORD_W-1:0] fifo_q [RES_DEPTH];
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            count_q;
	logic                        do_pop;

	assign res_count   = count_q;
	assign word_valid  = (count_q != '0);
	assign random_word = fifo_q[rd_ptr_q];
	assign do_pop      = word_valid && !word_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10: begin
					count_q <= count_q + CNT_W'(1);
				end
				2'b01: begin
					count_q <= count_q - CNT_W'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule
